// ===== sv/fca_pkg.sv =====
// Shared types and constants for the first-fit capacity allocator.
package fca_pkg;

    // Field widths of the item beats.
    localparam int unsigned KIND_W     = 1;
    localparam int unsigned SLOT_IDX_W = 10;
    localparam int unsigned AMT_W      = 31;
    localparam int unsigned COUNT_W    = 11;

    // Default number of slots held in the tree.
    localparam int unsigned SLOTS_DEFAULT = 1024;

    // Reset value of the slot count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQ  = 1'b1;

    // One input beat.
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [AMT_W-1:0]      amount;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic                  granted;
        logic [SLOT_IDX_W-1:0] chosen_slot;
        logic [AMT_W-1:0]      remaining;
    } t_out_item;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic             ge;
        logic [AMT_W-1:0] diff;
    } t_cmp_res;

endpackage

// ===== sv/first_fit_capacity_allocator.sv =====
// First-fit capacity allocator: top level with the slot count register.
//
// The block keeps a 31-bit capacity for each of SLOTS slots in a max tree held
// in one memory of 2*2^ceil(log2(SLOTS)) words. A load beat writes one slot and
// returns nothing; a request beat returns one result beat with the leftmost slot
// in use that holds at least the amount, and takes the amount from it. After
// reset the block clears the whole tree memory, one word a cycle, with the input
// stalled; slot count writes are taken throughout. One tree level is visited per
// cycle through the single read port of the tree memory: a granted request
// descends the tree and then updates the path from its leaf to the root before
// the next item is taken, a refused request only descends, a load updates the
// path from its leaf, and a load beyond the slots in use is dropped.
// A finished result waits in an output register while the next item is taken;
// a request that finishes while that register still holds a stalled beat waits
// until that beat is taken, and only then is the next item taken.
module first_fit_capacity_allocator #(
    parameter int unsigned SLOTS = fca_pkg::SLOTS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input item channel.
    input  logic                        i_valid,
    input  fca_pkg::t_in_item           i_data,
    output logic                        o_stall,
    // Result channel.
    output logic                        o_valid,
    output fca_pkg::t_out_item          o_data,
    input  logic                        i_stall,
    // Slot count write channel.
    input  logic                        i_cfg_valid,
    input  logic [fca_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                        o_cfg_ready
);
    import fca_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS) + 1;

    logic [COUNT_W-1:0] r_count;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AMT_W-1:0]   mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [AMT_W-1:0]   mem_rdata;
    logic [AMT_W-1:0]   cmp_a;
    logic [AMT_W-1:0]   cmp_b;
    t_cmp_res           cmp_res;

    // The slot count register takes every write beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // Sequencer.
    fca_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_count     (r_count),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_cmp_a     (cmp_a),
        .o_cmp_b     (cmp_b),
        .i_cmp       (cmp_res)
    );

    // Tree node store.
    fca_tree_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared compare and subtract unit.
    fca_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

endmodule

// ===== sv/fca_tree_mem.sv =====
// Node store of the max tree: one write port and one registered read port.
module fca_tree_mem #(
    parameter int unsigned SLOTS = fca_pkg::SLOTS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(SLOTS):0]       i_waddr,
    input  logic [fca_pkg::AMT_W-1:0]    i_wdata,
    input  logic [$clog2(SLOTS):0]       i_raddr,
    output logic [fca_pkg::AMT_W-1:0]    o_rdata
);
    import fca_pkg::*;

    localparam int unsigned AW    = $clog2(SLOTS) + 1;
    localparam int unsigned DEPTH = 2 ** AW;

    logic [AMT_W-1:0] r_mem [DEPTH];
    logic [AMT_W-1:0] r_rdata;

    // Write and read ports; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fca_cmp.sv =====
// Shared compare and subtract unit used by the descent, leaf and path update steps of the sequencer.
module fca_cmp (
    input  logic [fca_pkg::AMT_W-1:0] i_a,
    input  logic [fca_pkg::AMT_W-1:0] i_b,
    output fca_pkg::t_cmp_res         o_res
);
    import fca_pkg::*;

    // One magnitude compare and one subtraction on the same operands.
    always_comb begin
        o_res.ge   = (i_a >= i_b);
        o_res.diff = i_a - i_b;
    end

endmodule

// ===== sv/fca_ctrl.sv =====
// Sequencer of the allocator: clearing pass, tree descent, path update and result beat.
module fca_ctrl #(
    parameter int unsigned SLOTS = fca_pkg::SLOTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item channel.
    input  logic                          i_valid,
    input  fca_pkg::t_in_item             i_data,
    output logic                          o_stall,
    // Result channel.
    output logic                          o_valid,
    output fca_pkg::t_out_item            o_data,
    input  logic                          i_stall,
    // Current slot count.
    input  logic [fca_pkg::COUNT_W-1:0]   i_count,
    // Tree memory.
    output logic                          o_mem_we,
    output logic [$clog2(SLOTS):0]        o_mem_waddr,
    output logic [fca_pkg::AMT_W-1:0]     o_mem_wdata,
    output logic [$clog2(SLOTS):0]        o_mem_raddr,
    input  logic [fca_pkg::AMT_W-1:0]     i_mem_rdata,
    // Shared compare unit.
    output logic [fca_pkg::AMT_W-1:0]     o_cmp_a,
    output logic [fca_pkg::AMT_W-1:0]     o_cmp_b,
    input  fca_pkg::t_cmp_res             i_cmp
);
    import fca_pkg::*;

    localparam int unsigned LVL   = $clog2(SLOTS);
    localparam int unsigned AW    = LVL + 1;
    localparam int unsigned P     = 2 ** LVL;
    localparam int unsigned HALF0 = P / 2;
    localparam logic [AW-1:0] ROOT = AW'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DESC,
        S_LEAF,
        S_UP,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [AW-1:0]       r_node, n_node;
    logic [AW-1:0]       r_lo, n_lo;
    logic [AW-1:0]       r_half, n_half;
    logic [AW-1:0]       r_limit, n_limit;
    logic [AMT_W-1:0]    r_need, n_need;
    logic [AMT_W-1:0]    r_val, n_val;
    logic [KIND_W-1:0]   r_req, n_req;
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                accept;
    logic [31:0]         cnt_ext;
    logic [AW-1:0]       limit_now;
    logic                load_in_range;
    logic [AW-1:0]       leaf_addr;
    logic [AW-1:0]       span;
    logic                go_left;
    logic [AW-1:0]       child;
    logic [AW-1:0]       parent;
    logic [AMT_W-1:0]    up_max;
    logic                leaf_fit;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Slots in use: the count saturated at SLOTS.
    assign cnt_ext   = 32'(i_count);
    assign limit_now = (cnt_ext >= SLOTS) ? AW'(SLOTS) : cnt_ext[AW-1:0];

    // Leaf node of a load and whether the load lands on a slot in use.
    assign load_in_range = (32'(i_data.slot_index) < 32'(limit_now));
    assign leaf_addr     = AW'(32'(P) + 32'(i_data.slot_index));

    // Descent step: the left child is only trusted by its maximum when it lies
    // wholly below the limit; otherwise the right child is beyond the limit.
    assign span    = r_lo + r_half;
    assign go_left = (span > r_limit) || i_cmp.ge;
    assign child   = {r_node[AW-2:0], ~go_left};

    // Path update: the parent takes the larger of the two children.
    assign parent = r_node >> 1;
    assign up_max = i_cmp.ge ? r_val : i_mem_rdata;

    // A leaf qualifies when it is in use and holds enough capacity.
    assign leaf_fit = (r_lo < r_limit) && i_cmp.ge;

    // Operands of the shared unit follow the step in progress.
    always_comb begin
        o_cmp_a = i_mem_rdata;
        o_cmp_b = r_need;
        if (r_state == S_UP) begin
            o_cmp_a = r_val;
            o_cmp_b = i_mem_rdata;
        end
    end

    // Next state, memory port and working registers.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_lo        = r_lo;
        n_half      = r_half;
        n_limit     = r_limit;
        n_need      = r_need;
        n_val       = r_val;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_node;
        o_mem_wdata = r_val;
        o_mem_raddr = '0;

        // The result register empties when its beat is taken.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_mem_raddr = AW'(2);
                if (accept) begin
                    n_need  = i_data.amount;
                    n_limit = limit_now;
                    n_req   = i_data.kind;
                    if (i_data.kind == KIND_REQ) begin
                        n_node  = ROOT;
                        n_lo    = '0;
                        n_half  = AW'(HALF0);
                        n_state = S_DESC;
                    end else if (load_in_range) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = leaf_addr;
                        o_mem_wdata = i_data.amount;
                        o_mem_raddr = leaf_addr ^ AW'(1);
                        n_node      = leaf_addr;
                        n_val       = i_data.amount;
                        n_state     = S_UP;
                    end
                end
            end
            S_DESC: begin
                n_node = child;
                n_lo   = go_left ? r_lo : span;
                n_half = r_half >> 1;
                if (r_half == AW'(1)) begin
                    o_mem_raddr = child;
                    n_state     = S_LEAF;
                end else begin
                    o_mem_raddr = {child[AW-2:0], 1'b0};
                end
            end
            S_LEAF: begin
                if (leaf_fit) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_node;
                    o_mem_wdata = i_cmp.diff;
                    o_mem_raddr = r_node ^ AW'(1);
                    n_val       = i_cmp.diff;
                    n_res       = '{granted: 1'b1,
                                    chosen_slot: SLOT_IDX_W'(r_lo),
                                    remaining: i_cmp.diff};
                    n_state     = S_UP;
                end else begin
                    n_res   = '0;
                    n_state = S_FIN;
                end
            end
            S_UP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = parent;
                o_mem_wdata = up_max;
                o_mem_raddr = parent ^ AW'(1);
                n_node      = parent;
                n_val       = up_max;
                if (parent == ROOT) begin
                    n_state = (r_req == KIND_REQ) ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; the working registers need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_node  <= n_node;
        r_lo    <= n_lo;
        r_half  <= n_half;
        r_limit <= n_limit;
        r_need  <= n_need;
        r_val   <= n_val;
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // The span of a child subtree halves each level, so it is always a single bit.
    a_half_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DESC) |-> $onehot(r_half))
        else $error("descent span is not a power of two");

    // The leaf step always sits on a leaf node.
    a_leaf_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAF) |-> r_node[AW-1])
        else $error("leaf step on an internal node");

    // The path update never starts from the root.
    a_up_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_node != ROOT))
        else $error("path update started at the root");

    // Only a request produces a result beat.
    a_fin_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_req == KIND_REQ))
        else $error("result pending for a load");

    // The clearing pass runs once after reset.
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass re-entered");
`endif

endmodule

// ===== tb/tb_first_fit_capacity_allocator.sv =====
// Self-checking testbench for the first-fit capacity allocator, with directed and random beats.
module tb_first_fit_capacity_allocator;
    import fca_pkg::*;

    localparam int unsigned NUM_SLOTS   = SLOTS_DEFAULT;
    localparam int unsigned SETTLE_CYC  = 32;
    localparam int unsigned IDLE_LIMIT  = 20000;
    localparam int unsigned MAX_REPORTS = 40;
    localparam int unsigned PHASES      = 13;
    localparam logic [AMT_W-1:0] AMT_MAX = '1;

    typedef enum int unsigned {STALL_NONE, STALL_RANDOM, STALL_BURSTY} t_stall_mode;
    typedef enum int unsigned {SCALE_TINY, SCALE_MID, SCALE_FULL} t_amt_scale;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               cfg_ready;

    // Slot capacities and slot count as the block should hold them.
    logic [AMT_W-1:0]   slot_capacity [NUM_SLOTS];
    logic [COUNT_W-1:0] slot_count_model = COUNT_RESET;

    t_in_item    pending_items [$];
    t_out_item   expected_grants [$];
    int unsigned error_count = 0;

    logic [COUNT_W-1:0] phase_counts [PHASES] =
        '{1, 2, 1024, 2047, 3, 0, 64, 1024, 600, 17, 0, 1024, 5};

    first_fit_capacity_allocator #(
        .SLOTS(NUM_SLOTS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .i_data     (in_data),
        .o_stall    (in_stall),
        .o_valid    (out_valid),
        .o_data     (out_data),
        .i_stall    (out_stall),
        .i_cfg_valid(cfg_valid),
        .i_cfg_data (cfg_data),
        .o_cfg_ready(cfg_ready)
    );

    // Clock with a period of four time units.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
        error_count++;
    endtask

    // Applies one accepted beat to the slot array and queues the grant it causes.
    task automatic predict_grant(input t_in_item item);
        int unsigned live;
        t_out_item   res;
        bit          found;
        live  = (slot_count_model > NUM_SLOTS) ? NUM_SLOTS : slot_count_model;
        res   = '0;
        found = 1'b0;
        if (item.kind == KIND_LOAD) begin
            if (item.slot_index < live) begin
                slot_capacity[item.slot_index] = item.amount;
            end
        end else begin
            // The tree descent picks the leftmost slot in use that fits.
            for (int unsigned s = 0; s < live && !found; s++) begin
                if (slot_capacity[s] >= item.amount) begin
                    found            = 1'b1;
                    slot_capacity[s] = slot_capacity[s] - item.amount;
                    res.granted      = 1'b1;
                    res.chosen_slot  = SLOT_IDX_W'(s);
                    res.remaining    = slot_capacity[s];
                end
            end
            expected_grants.push_back(res);
        end
    endtask

    // Compares one result beat with the oldest expected grant.
    task automatic check_grant(input t_out_item got);
        t_out_item want;
        if (expected_grants.size() == 0) begin
            report_mismatch($sformatf("result with none expected: granted %0d slot %0d rem %0d",
                                      got.granted, got.chosen_slot, got.remaining));
        end else begin
            want = expected_grants.pop_front();
            if (got.granted !== want.granted) begin
                report_mismatch($sformatf("granted %0d, expected %0d",
                                          got.granted, want.granted));
            end
            if (got.chosen_slot !== want.chosen_slot) begin
                report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                          got.chosen_slot, want.chosen_slot));
            end
            if (got.remaining !== want.remaining) begin
                report_mismatch($sformatf("remaining %0d, expected %0d",
                                          got.remaining, want.remaining));
            end
        end
    endtask

    // Driver: sends pending beats in bursts of random length with random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts accepted beats, drives the result stall.
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_tick  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    logic        stall_next;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            slot_count_model = COUNT_RESET;
            foreach (slot_capacity[s]) begin
                slot_capacity[s] = '0;
            end
            idle_cycles = 0;
        end else begin
            // Results of earlier beats are checked before this edge's beat is predicted.
            if (out_valid && !out_stall) begin
                check_grant(out_data);
            end
            if (in_valid && !in_stall) begin
                predict_grant(in_data);
            end
            if (cfg_valid && cfg_ready) begin
                slot_count_model = cfg_data;
            end

            // Count cycles in which no channel moves a beat.
            if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end

            // The stall pattern switches at random between none, random and bursty stalls.
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                stall_left = $urandom_range(50, 400);
            end else begin
                stall_left--;
            end
            stall_tick++;
            case (stall_mode)
                STALL_NONE: begin
                    stall_next = 1'b0;
                end
                STALL_RANDOM: begin
                    stall_next = ($urandom_range(0, 1) == 1);
                end
                default: begin
                    stall_next = (stall_tick % 29) < 17;
                end
            endcase
            out_stall <= stall_next;

            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [AMT_W-1:0] pick_amount(input t_amt_scale scale);
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return AMT_MAX;
            end
            default: begin
                case (scale)
                    SCALE_TINY: return AMT_W'($urandom_range(0, 15));
                    SCALE_MID:  return AMT_W'($urandom_range(0, 1000));
                    default:    return AMT_W'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic queue_load(input int unsigned slot, input logic [AMT_W-1:0] amt);
        t_in_item item;
        item.kind       = KIND_LOAD;
        item.slot_index = SLOT_IDX_W'(slot);
        item.amount     = amt;
        pending_items.push_back(item);
    endtask

    // The slot field of a request is ignored, so it carries random bits.
    task automatic queue_request(input logic [AMT_W-1:0] amt);
        t_in_item item;
        item.kind       = KIND_REQ;
        item.slot_index = SLOT_IDX_W'($urandom);
        item.amount     = amt;
        pending_items.push_back(item);
    endtask

    // Waits until every beat has gone in and every grant has come back, then lets
    // a trailing load finish inside the block. The queues are looked at on the
    // falling edge, once the driver and the monitor have settled.
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || in_valid || expected_grants.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [COUNT_W-1:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly loads inside the slots in use and requests on the same scale of amount.
    task automatic queue_random_phase(input logic [COUNT_W-1:0] count, input int unsigned n);
        int unsigned live;
        t_amt_scale  scale;
        live  = (count > NUM_SLOTS) ? NUM_SLOTS : count;
        scale = t_amt_scale'($urandom_range(0, 2));
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 4) begin
                if (live != 0 && $urandom_range(0, 7) != 0) begin
                    queue_load($urandom_range(0, live - 1), pick_amount(scale));
                end else begin
                    queue_load($urandom_range(0, NUM_SLOTS - 1), pick_amount(scale));
                end
            end else begin
                queue_request(pick_amount(scale));
            end
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        phase_counts[9]  = COUNT_W'($urandom_range(1, 2047));
        phase_counts[12] = COUNT_W'($urandom_range(1, 2047));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset count with a cleared tree: a zero amount fits slot 0, anything else fails.
        queue_request('0);
        queue_request(1);
        // Extreme capacities at both ends of the slot range.
        queue_load(1023, AMT_MAX);
        queue_load(0, 5);
        queue_request(AMT_MAX);
        queue_request(5);
        queue_request('0);
        // Two neighbours either side of the midpoint: the left one is used first.
        queue_load(512, 100);
        queue_load(511, 100);
        queue_request(60);
        queue_request(60);
        queue_request(41);

        // A count above the slot total saturates.
        write_slot_count(2047);
        queue_load(1023, AMT_MAX);
        queue_request(AMT_MAX);

        // With no slot in use, loads are dropped and every request is refused.
        write_slot_count(0);
        queue_load(0, 9);
        queue_request('0);
        queue_request(1);

        // Lowering the count hides a loaded slot but keeps its capacity.
        write_slot_count(1024);
        queue_load(700, 50);
        write_slot_count(600);
        queue_request(50);
        queue_load(700, 1);
        write_slot_count(1024);
        queue_request(50);

        // Random phases over a spread of slot counts.
        foreach (phase_counts[p]) begin
            write_slot_count(phase_counts[p]);
            queue_random_phase(phase_counts[p], (phase_counts[p] == 0) ? 20 : 115);
        end

        wait_until_idle();
        if (expected_grants.size() != 0) begin
            report_mismatch($sformatf("%0d grants never arrived", expected_grants.size()));
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== first_fit_capacity_allocator.f =====
sv/fca_pkg.sv
sv/fca_tree_mem.sv
sv/fca_cmp.sv
sv/fca_ctrl.sv
sv/first_fit_capacity_allocator.sv
tb/tb_first_fit_capacity_allocator.sv
